// File: rtl/chcr_pkg.sv
// ----------------------------------------------------------------------------
// chcr_pkg - shared definitions for the CRC-checked hex command receiver
// Character codes, status codes, parse phases and the byte-wide helpers
// (CRC-8 update and hex digit decode) used by the receiver.
// ----------------------------------------------------------------------------
package chcr_pkg;

  localparam int unsigned OutputCountDefault    = 13;
  localparam int unsigned LineBufferSizeDefault = 32;

  localparam int unsigned MaskW = 13;
  localparam logic [15:0] TimeoutResetMs = 16'd500;

  localparam logic [7:0] CrcPoly = 8'h07;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_K     = 8'h4B;

  // Status codes reported with every result beat
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_APPLIED    = 4'd1;
  localparam logic [3:0] ST_NO_PREFIX  = 4'd2;
  localparam logic [3:0] ST_NO_STAR    = 4'd3;
  localparam logic [3:0] ST_BAD_HEX    = 4'd4;
  localparam logic [3:0] ST_CRC_ERR    = 4'd5;
  localparam logic [3:0] ST_MASK_LEN   = 4'd6;
  localparam logic [3:0] ST_TIMEOUT    = 4'd7;
  localparam logic [3:0] ST_OVERFLOW   = 4'd8;

  typedef enum logic [6:0] {
    PH_SKIP       = 7'b0000001,
    PH_GOT_K      = 7'b0000010,
    PH_MASK       = 7'b0000100,
    PH_CRC        = 7'b0001000,
    PH_DONE       = 7'b0010000,
    PH_BAD_PREFIX = 7'b0100000,
    PH_BAD_HEX    = 7'b1000000
  } phase_t;

  // CRC-8, MSB first, no reflection, no final xor.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic hex_ok(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      n = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      n = c[3:0] + 4'd9;
    end
    return n;
  endfunction

endpackage

// File: rtl/crc_checked_hex_command_receiver_top.sv
// ----------------------------------------------------------------------------
// crc_checked_hex_command_receiver_top - line parser for CRC-8 checked
// "K:<hex mask>*<crc>" commands with a millisecond output timeout.
//
//   Channel   Dir  Signals                          Contents
//   s_axis    in   tvalid/tready/tdata[7:0]/tuser   rx_byte, tuser = req_type
//   m_axis    out  tvalid/tready/tdata[39:0]        one result beat per input
//   cfg       in   cfg_wr_en/cfg_wr_data[15:0]      timeout_ms register
//
// Every input beat is handled as it is accepted: the parse and timer state
// updates at the accepting edge and the result lands in the output register.
// One beat per cycle is sustained; s_axis_tready drops only while a result
// waits in the output register and m_axis_tready is low.
// Synchronous active-high reset clears the parser, timer and applied mask and
// loads a timeout of 500 ticks; no clearing pass follows.
// ----------------------------------------------------------------------------
module crc_checked_hex_command_receiver_top #(
  parameter int unsigned OUTPUT_COUNT     = chcr_pkg::OutputCountDefault,
  parameter int unsigned LINE_BUFFER_SIZE = chcr_pkg::LineBufferSizeDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] req_type (1 = millisecond tick)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [12:0] relay_mask, [13] led_on,
                                      // [17:14] status, [25:18] computed_crc,
                                      // [33:26] received_crc, [39:34] zero
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import chcr_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_BUFFER_SIZE);
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_BUFFER_SIZE - 1);
  localparam logic [MaskW-1:0] OutMask =
    (OUTPUT_COUNT >= MaskW) ? {MaskW{1'b1}} : MaskW'((1 << OUTPUT_COUNT) - 1);

  logic [15:0]      timeout_ms;
  phase_t           phase, phase_next;
  logic             frozen, frozen_next;
  logic [LenW-1:0]  line_length, line_length_next;
  logic [7:0]       running_crc, running_crc_next;
  logic [MaskW-1:0] mask_accum, mask_accum_next;
  logic [2:0]       mask_char_count, mask_char_count_next;
  logic             mask_digits_stopped, mask_digits_stopped_next;
  logic [7:0]       crc_digits, crc_digits_next;
  logic [1:0]       crc_digit_count, crc_digit_count_next;
  logic [MaskW-1:0] applied_mask, applied_mask_next;
  logic [15:0]      elapsed_ms, elapsed_ms_next;

  logic [3:0]       status_next;
  logic [7:0]       ccrc_next, rcrc_next;
  logic             clear_req;

  logic             s_fire;
  logic [7:0]       c;
  logic             c_hex;
  logic [3:0]       c_nib;
  logic [7:0]       c_crc;
  logic [16:0]      elapsed_inc;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign c             = s_axis_tdata;
  assign c_hex         = hex_ok(c);
  assign c_nib         = hex_nibble(c);
  assign c_crc         = crc8_update(running_crc, c);
  assign elapsed_inc   = {1'b0, elapsed_ms} + 17'd1;

  always_comb begin
    phase_next               = phase;
    frozen_next              = frozen;
    line_length_next         = line_length;
    running_crc_next         = running_crc;
    mask_accum_next          = mask_accum;
    mask_char_count_next     = mask_char_count;
    mask_digits_stopped_next = mask_digits_stopped;
    crc_digits_next          = crc_digits;
    crc_digit_count_next     = crc_digit_count;
    applied_mask_next        = applied_mask;
    elapsed_ms_next          = elapsed_ms;
    status_next              = ST_IDLE;
    ccrc_next                = 8'd0;
    rcrc_next                = 8'd0;
    clear_req                = 1'b0;

    if (s_axis_tuser) begin
      if (elapsed_inc > {1'b0, timeout_ms}) begin
        if (applied_mask != '0) begin
          applied_mask_next = '0;
          status_next       = ST_TIMEOUT;
        end
        elapsed_ms_next = 16'd0;
      end else begin
        elapsed_ms_next = elapsed_inc[15:0];
      end
    end else if (c == CH_LF) begin
      // The line is judged on its phase; a NUL only froze further parsing.
      clear_req = 1'b1;
      unique case (phase)
        PH_SKIP, PH_GOT_K, PH_BAD_PREFIX: status_next = ST_NO_PREFIX;
        PH_MASK: begin
          status_next = ST_NO_STAR;
          ccrc_next   = running_crc;
        end
        PH_CRC, PH_BAD_HEX: begin
          status_next = ST_BAD_HEX;
          ccrc_next   = running_crc;
        end
        default: begin
          ccrc_next = running_crc;
          rcrc_next = crc_digits;
          if (running_crc != crc_digits) begin
            status_next = ST_CRC_ERR;
          end else if ((mask_char_count == 3'd0) || (mask_char_count > 3'd4)) begin
            status_next = ST_MASK_LEN;
          end else begin
            applied_mask_next = mask_accum & OutMask;
            elapsed_ms_next   = 16'd0;
            status_next       = ST_APPLIED;
          end
        end
      endcase
    end else if (c != CH_CR) begin
      if (line_length < LenMax) begin
        line_length_next = line_length + 1'b1;
        if (!frozen) begin
          if (c == CH_NUL) begin
            frozen_next = 1'b1;
          end else begin
            unique case (phase)
              PH_SKIP: begin
                if ((c == CH_SPACE) || (c == CH_TAB)) begin
                  phase_next = PH_SKIP;
                end else if (c == CH_K) begin
                  running_crc_next = c_crc;
                  phase_next       = PH_GOT_K;
                end else begin
                  phase_next = PH_BAD_PREFIX;
                end
              end
              PH_GOT_K: begin
                if (c == CH_COLON) begin
                  running_crc_next = c_crc;
                  phase_next       = PH_MASK;
                end else begin
                  phase_next = PH_BAD_PREFIX;
                end
              end
              PH_MASK: begin
                if (c == CH_STAR) begin
                  phase_next = PH_CRC;
                end else begin
                  running_crc_next = c_crc;
                  if ((mask_char_count < 3'd4) && !mask_digits_stopped) begin
                    if (!c_hex) begin
                      mask_digits_stopped_next = 1'b1;
                    end else begin
                      mask_accum_next = {mask_accum[MaskW-5:0], c_nib};
                    end
                  end
                  if (mask_char_count < 3'd5) begin
                    mask_char_count_next = mask_char_count + 3'd1;
                  end
                end
              end
              PH_CRC: begin
                if (!c_hex) begin
                  phase_next = PH_BAD_HEX;
                end else begin
                  crc_digits_next      = {crc_digits[3:0], c_nib};
                  crc_digit_count_next = crc_digit_count + 2'd1;
                  if (crc_digit_count != 2'd0) begin
                    phase_next = PH_DONE;
                  end
                end
              end
              default: phase_next = phase;
            endcase
          end
        end
      end else begin
        clear_req   = 1'b1;
        status_next = ST_OVERFLOW;
      end
    end

    if (clear_req) begin
      phase_next               = PH_SKIP;
      frozen_next              = 1'b0;
      line_length_next         = '0;
      running_crc_next         = 8'd0;
      mask_accum_next          = '0;
      mask_char_count_next     = 3'd0;
      mask_digits_stopped_next = 1'b0;
      crc_digits_next          = 8'd0;
      crc_digit_count_next     = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TimeoutResetMs;
    end else if (cfg_wr_en) begin
      timeout_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_SKIP;
      frozen              <= 1'b0;
      line_length         <= '0;
      running_crc         <= 8'd0;
      mask_accum          <= '0;
      mask_char_count     <= 3'd0;
      mask_digits_stopped <= 1'b0;
      crc_digits          <= 8'd0;
      crc_digit_count     <= 2'd0;
      applied_mask        <= '0;
      elapsed_ms          <= 16'd0;
    end else if (s_fire) begin
      phase               <= phase_next;
      frozen              <= frozen_next;
      line_length         <= line_length_next;
      running_crc         <= running_crc_next;
      mask_accum          <= mask_accum_next;
      mask_char_count     <= mask_char_count_next;
      mask_digits_stopped <= mask_digits_stopped_next;
      crc_digits          <= crc_digits_next;
      crc_digit_count     <= crc_digit_count_next;
      applied_mask        <= applied_mask_next;
      elapsed_ms          <= elapsed_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_axis_tdata <= {6'd0, rcrc_next, ccrc_next, status_next,
                       (applied_mask_next != '0), applied_mask_next};
    end
  end

  // A stalled result must be the only thing that holds off new input.
  assert property (@(posedge clk) disable iff (rst) !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled without a pending result");

  assert property (@(posedge clk) disable iff (rst) s_fire |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> (crc_digit_count == 2'd2))
    else $error("CRC field complete with wrong digit count");

  assert property (@(posedge clk) disable iff (rst)
    (line_length <= LenMax) && (mask_char_count <= 3'd5))
    else $error("line or mask counter out of range");

endmodule
